[hdl/pvrt_pkg.sv]
// Shared types, constants and helpers for the path-vector route table
package pvrt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int PATH_MAX    = 8;
    localparam int ID_BITS     = 4;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int COST_W      = 16;
    localparam int LEN_W       = 4;
    localparam int PATH_W      = 32;
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = $clog2(Q_DEPTH);
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_ADD_NBR  = 3'd1,
        CMD_ADD_SELF = 3'd2,
        CMD_UPDATE   = 3'd3,
        CMD_DEAD     = 3'd4,
        CMD_READ     = 3'd5,
        CMD_RSVD6    = 3'd6,
        CMD_RSVD7    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2,
        STS_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [ID_BITS-1:0]  dest;
        logic [ID_BITS-1:0]  hop;
        logic [COST_W-1:0]   total;
        logic [COST_W-1:0]   cost;
        logic [LEN_W-1:0]    plen;
        logic [PATH_W-1:0]   path;
        logic                full;
        logic                mine;
        logic [IDX_W-1:0]    idx;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic                changed;
        logic [CNT_W-1:0]    entry_count;
        logic [ID_BITS-1:0]  dest;
        logic [ID_BITS-1:0]  hop;
        logic [COST_W-1:0]   cost;
        logic [LEN_W-1:0]    plen;
        logic [PATH_W-1:0]   path;
    } result_t;

    function automatic logic [PATH_W-1:0] prefix_path(
        input logic [ID_BITS-1:0] self_id,
        input logic [PATH_W-1:0]  adv,
        input logic [LEN_W-1:0]   len
    );
        logic [PATH_W-1:0] p;
        p = '0;
        p[ID_BITS-1:0] = self_id;
        for (int k = 0; k < PATH_MAX - 1; k++) begin
            if (LEN_W'(k) < len) begin
                p[(k+1)*ID_BITS +: ID_BITS] = adv[k*ID_BITS +: ID_BITS];
            end
        end
        return p;
    endfunction

    function automatic logic id_in_path(
        input logic [ID_BITS-1:0] self_id,
        input logic [PATH_W-1:0]  adv,
        input logic [LEN_W-1:0]   len
    );
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < PATH_MAX; k++) begin
            if (LEN_W'(k) < len && adv[k*ID_BITS +: ID_BITS] == self_id) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[hdl/pvrt_front.sv]
// Front end: accepts commands, saturates costs and prepares new route fields
module pvrt_front import pvrt_pkg::*; (
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          cmd,
    input  logic [ID_BITS-1:0]  neighbor_id,
    input  logic [COST_W-1:0]   link_cost,
    input  logic [ID_BITS-1:0]  route_dest,
    input  logic [COST_W-1:0]   route_cost,
    input  logic [LEN_W-1:0]    route_path_len,
    input  logic [PATH_W-1:0]   route_path,
    input  logic [IDX_W-1:0]    entry_index,
    input  logic [ID_BITS-1:0]  my_id,
    input  logic [COST_W-1:0]   infinity_cost,
    input  logic                q_full,
    output logic                push,
    output item_t               item
);

    logic [COST_W:0]    sum;
    logic [COST_W-1:0]  total;
    logic [LEN_W-1:0]   len;
    logic               full;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        sum   = {1'b0, route_cost} + {1'b0, link_cost};
        total = (sum >= {1'b0, infinity_cost}) ? infinity_cost : sum[COST_W-1:0];
        len   = (route_path_len > LEN_W'(PATH_MAX)) ? LEN_W'(PATH_MAX) : route_path_len;
        full  = (len >= LEN_W'(PATH_MAX));

        item       = '0;
        item.cmd   = cmd_t'(cmd);
        item.total = total;
        item.full  = full;
        item.mine  = id_in_path(my_id, route_path, len);
        item.idx   = entry_index;
        item.hop   = neighbor_id;
        unique case (cmd_t'(cmd))
            CMD_ADD_NBR:
            begin
                item.dest = neighbor_id;
                item.cost = link_cost;
                item.plen = LEN_W'(2);
                item.path = PATH_W'({neighbor_id, my_id});
            end
            CMD_ADD_SELF:
            begin
                item.dest = my_id;
                item.hop  = my_id;
                item.cost = '0;
                item.plen = LEN_W'(1);
                item.path = PATH_W'(my_id);
            end
            CMD_UPDATE:
            begin
                item.dest = route_dest;
                item.cost = full ? infinity_cost : total;
                item.plen = full ? LEN_W'(PATH_MAX) : len + LEN_W'(1);
                item.path = prefix_path(my_id, route_path, len);
            end
            default:
            begin
                item.dest = route_dest;
            end
        endcase
    end

endmodule

[hdl/pvrt_queue.sv]
// Short command queue between the front end and the table sequencer
module pvrt_queue import pvrt_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_item,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output item_t  q_item
);

    item_t              slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_pop;

    assign full    = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/pvrt_back.sv]
// Table sequencer: holds the route table, scans it and registers the result
module pvrt_back import pvrt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               pop,
    input  logic [COST_W-1:0]  infinity_cost,
    output logic               out_valid,
    input  logic               out_stall,
    output result_t            out_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg, out_res_next;

    logic [ID_BITS-1:0] dest_mem [MAX_ENTRIES];
    logic [ID_BITS-1:0] hop_mem  [MAX_ENTRIES];
    logic [COST_W-1:0]  cost_mem [MAX_ENTRIES];
    logic [LEN_W-1:0]   plen_mem [MAX_ENTRIES];
    logic [PATH_W-1:0]  path_mem [MAX_ENTRIES];

    logic [IDX_W-1:0]   rd_idx;
    logic [ID_BITS-1:0] rd_dest, rd_hop;
    logic [COST_W-1:0]  rd_cost;
    logic [LEN_W-1:0]   rd_plen;
    logic [PATH_W-1:0]  rd_path;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [ID_BITS-1:0] wr_dest, wr_hop;
    logic [COST_W-1:0]  wr_cost;
    logic [LEN_W-1:0]   wr_plen;
    logic [PATH_W-1:0]  wr_path;
    logic               take;

    assign rd_idx  = ptr_reg[IDX_W-1:0];
    assign rd_dest = dest_mem[rd_idx];
    assign rd_hop  = hop_mem[rd_idx];
    assign rd_cost = cost_mem[rd_idx];
    assign rd_plen = plen_mem[rd_idx];
    assign rd_path = path_mem[rd_idx];

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = rd_idx;
        wr_dest        = rd_dest;
        wr_hop         = rd_hop;
        wr_cost        = rd_cost;
        wr_plen        = rd_plen;
        wr_path        = rd_path;
        take           = (rd_hop == item_reg.hop) ? (rd_cost != item_reg.total)
                         : ((item_reg.total < rd_cost) && !item_reg.mine);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    item_next  = q_item;
                    ptr_next   = '0;
                    res_next   = '0;
                    state_next = S_EMIT;
                    unique case (q_item.cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_ADD_NBR, CMD_ADD_SELF:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                res_next.status = STS_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_idx           = count_reg[IDX_W-1:0];
                                wr_dest          = q_item.dest;
                                wr_hop           = q_item.hop;
                                wr_cost          = q_item.cost;
                                wr_plen          = q_item.plen;
                                wr_path          = q_item.path;
                                count_next       = count_reg + CNT_W'(1);
                                res_next.changed = 1'b1;
                            end
                        end
                        CMD_UPDATE, CMD_DEAD:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_READ:
                        begin
                            if (CNT_W'(q_item.idx) >= count_reg)
                            begin
                                res_next.status = STS_RANGE;
                            end
                            else
                            begin
                                ptr_next   = CNT_W'(q_item.idx);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (ptr_reg == count_reg)
                begin
                    state_next = S_EMIT;
                    if (item_reg.cmd == CMD_UPDATE)
                    begin
                        if (count_reg >= CNT_W'(MAX_ENTRIES))
                        begin
                            res_next.status = STS_FULL;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_idx           = count_reg[IDX_W-1:0];
                            wr_dest          = item_reg.dest;
                            wr_hop           = item_reg.hop;
                            wr_cost          = item_reg.cost;
                            wr_plen          = item_reg.plen;
                            wr_path          = item_reg.path;
                            count_next       = count_reg + CNT_W'(1);
                            res_next.changed = 1'b1;
                        end
                    end
                end
                else if (item_reg.cmd == CMD_UPDATE)
                begin
                    if (rd_dest == item_reg.dest)
                    begin
                        state_next = S_EMIT;
                        if (take)
                        begin
                            wr_en            = 1'b1;
                            wr_hop           = item_reg.hop;
                            wr_cost          = item_reg.cost;
                            res_next.changed = 1'b1;
                            if (!item_reg.full)
                            begin
                                wr_plen = item_reg.plen;
                                wr_path = item_reg.path;
                            end
                        end
                    end
                    else
                    begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (rd_hop == item_reg.hop)
                    begin
                        wr_en   = 1'b1;
                        wr_cost = infinity_cost;
                        if (rd_cost != infinity_cost)
                        begin
                            res_next.changed = 1'b1;
                        end
                    end
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_READ:
            begin
                res_next.dest = rd_dest;
                res_next.hop  = rd_hop;
                res_next.cost = rd_cost;
                res_next.plen = rd_plen;
                res_next.path = rd_path;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_res_next             = res_reg;
                    out_res_next.entry_count = count_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            res_reg       <= '0;
            out_res_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
            out_res_reg   <= out_res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dest_mem[wr_idx] <= wr_dest;
            hop_mem[wr_idx]  <= wr_hop;
            cost_mem[wr_idx] <= wr_cost;
            plen_mem[wr_idx] <= wr_plen;
            path_mem[wr_idx] <= wr_path;
        end
    end

endmodule

[hdl/path_vector_route_table.sv]
// Path-vector route table: top level with configuration registers
// Clear, add and reserved commands go from idle straight to emit; read passes through
// a read state; update and neighbour dead scan the table one entry per cycle, update
// stopping at the matching entry and neighbour dead scanning the whole table.
// The sequencer handles one command at a time, taking another only after the last result is registered; a
// two-entry queue decouples intake. Reset: route count, queue and output cleared;
// my_id 0, infinity_cost 999; table contents are undefined until written.
module path_vector_route_table import pvrt_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          cmd,
    input  logic [ID_BITS-1:0]  neighbor_id,
    input  logic [COST_W-1:0]   link_cost,
    input  logic [ID_BITS-1:0]  route_dest,
    input  logic [COST_W-1:0]   route_cost,
    input  logic [LEN_W-1:0]    route_path_len,
    input  logic [PATH_W-1:0]   route_path,
    input  logic [IDX_W-1:0]    entry_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic                changed,
    output logic [CNT_W-1:0]    entry_count,
    output logic [ID_BITS-1:0]  out_dest,
    output logic [ID_BITS-1:0]  out_next_hop,
    output logic [COST_W-1:0]   out_cost,
    output logic [LEN_W-1:0]    out_path_len,
    output logic [PATH_W-1:0]   out_path
);

    logic [ID_BITS-1:0] my_id_reg;
    logic [COST_W-1:0]  inf_reg;
    logic               q_full, push, pop, q_valid;
    item_t              push_item, q_item;
    result_t            res;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(inf_reg) : 32'(my_id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_id_reg <= '0;
            inf_reg   <= COST_W'(999);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2])
            begin
                inf_reg <= pwdata[COST_W-1:0];
            end
            else
            begin
                my_id_reg <= pwdata[ID_BITS-1:0];
            end
        end
    end

    pvrt_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .neighbor_id    (neighbor_id),
        .link_cost      (link_cost),
        .route_dest     (route_dest),
        .route_cost     (route_cost),
        .route_path_len (route_path_len),
        .route_path     (route_path),
        .entry_index    (entry_index),
        .my_id          (my_id_reg),
        .infinity_cost  (inf_reg),
        .q_full         (q_full),
        .push           (push),
        .item           (push_item)
    );

    pvrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    pvrt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .infinity_cost (inf_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_res       (res)
    );

    assign status       = res.status;
    assign changed      = res.changed;
    assign entry_count  = res.entry_count;
    assign out_dest     = res.dest;
    assign out_next_hop = res.hop;
    assign out_cost     = res.cost;
    assign out_path_len = res.plen;
    assign out_path     = res.path;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_full_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_FULL |-> !changed)
        else $error("dropped route reported as change");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_RANGE |-> out_cost == '0 && out_path == '0 && !changed)
        else $error("out of range read returned data");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("queue written while full");

endmodule

[tb/path_vector_route_table_tb.sv]
// Self-checking testbench for the path-vector route table, with an inline route predictor
`timescale 1ns / 100ps

module path_vector_route_table_tb;
    import pvrt_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [3:0]  nbr;
        logic [15:0] link;
        logic [3:0]  rdest;
        logic [15:0] rcost;
        logic [3:0]  rlen;
        logic [31:0] rpath;
        logic [3:0]  idx;
    } route_cmd_t;

    localparam logic [2:0] ADDR_MY_ID = 3'd0;
    localparam logic [2:0] ADDR_INF   = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic [2:0]  cmd;
    logic [3:0]  neighbor_id, route_dest, route_path_len, entry_index;
    logic [15:0] link_cost, route_cost;
    logic [31:0] route_path;
    logic        out_valid, out_stall;
    logic [1:0]  status;
    logic        changed;
    logic [4:0]  entry_count;
    logic [3:0]  out_dest, out_next_hop, out_path_len;
    logic [15:0] out_cost;
    logic [31:0] out_path;

    // predictor state
    logic [3:0]  tbl_dest [16];
    logic [3:0]  tbl_hop  [16];
    logic [15:0] tbl_cost [16];
    logic [3:0]  tbl_len  [16];
    logic [31:0] tbl_path [16];
    int          tbl_count;
    logic [3:0]  cur_my_id;
    logic [15:0] cur_inf;

    result_t     pending_routes[$];
    int          mismatches;
    int          items_sent, results_seen, reads_ok, full_drops;
    bit          send_free, recv_free;
    int          hold_left;

    path_vector_route_table dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] own_prefix(logic [31:0] adv, int n);
        logic [31:0] p;
        p = '0;
        p[3:0] = cur_my_id;
        for (int k = 0; k < n; k++)
            if (k + 1 < 8)
                p[(k+1)*4 +: 4] = adv[k*4 +: 4];
        return p;
    endfunction

    function automatic result_t predict_route(route_cmd_t c);
        result_t r;
        logic [16:0] total;
        int len;
        bit full, found, take, mine;
        r = '0;
        r.status = STS_OK;
        case (c.cmd)
            CMD_CLEAR: tbl_count = 0;
            CMD_ADD_NBR, CMD_ADD_SELF:
            begin
                if (tbl_count >= 16)
                    r.status = STS_FULL;
                else
                begin
                    if (c.cmd == CMD_ADD_NBR)
                    begin
                        tbl_dest[tbl_count] = c.nbr;
                        tbl_hop[tbl_count]  = c.nbr;
                        tbl_cost[tbl_count] = c.link;
                        tbl_len[tbl_count]  = 4'd2;
                        tbl_path[tbl_count] = {24'd0, c.nbr, cur_my_id};
                    end
                    else
                    begin
                        tbl_dest[tbl_count] = cur_my_id;
                        tbl_hop[tbl_count]  = cur_my_id;
                        tbl_cost[tbl_count] = '0;
                        tbl_len[tbl_count]  = 4'd1;
                        tbl_path[tbl_count] = {28'd0, cur_my_id};
                    end
                    tbl_count++;
                    r.changed = 1'b1;
                end
            end
            CMD_UPDATE:
            begin
                total = c.rcost + c.link;
                if (total >= cur_inf)
                    total = cur_inf;
                len = (c.rlen > 8) ? 8 : c.rlen;
                full = (len >= 8);
                found = 0;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (!found && tbl_dest[i] == c.rdest)
                    begin
                        found = 1;
                        if (tbl_hop[i] == c.nbr)
                            take = (tbl_cost[i] != total[15:0]);
                        else
                        begin
                            mine = 0;
                            for (int k = 0; k < len; k++)
                                if (c.rpath[k*4 +: 4] == cur_my_id)
                                    mine = 1;
                            take = (total < tbl_cost[i]) && !mine;
                        end
                        if (take)
                        begin
                            tbl_hop[i] = c.nbr;
                            r.changed = 1'b1;
                            if (full)
                                tbl_cost[i] = cur_inf;
                            else
                            begin
                                tbl_cost[i] = total[15:0];
                                tbl_len[i]  = 4'(len + 1);
                                tbl_path[i] = own_prefix(c.rpath, len);
                            end
                        end
                    end
                end
                if (!found)
                begin
                    if (tbl_count >= 16)
                        r.status = STS_FULL;
                    else
                    begin
                        tbl_dest[tbl_count] = c.rdest;
                        tbl_hop[tbl_count]  = c.nbr;
                        tbl_cost[tbl_count] = full ? cur_inf : total[15:0];
                        tbl_len[tbl_count]  = full ? 4'd8 : 4'(len + 1);
                        tbl_path[tbl_count] = own_prefix(c.rpath, full ? 7 : len);
                        tbl_count++;
                        r.changed = 1'b1;
                    end
                end
            end
            CMD_DEAD:
            begin
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_hop[i] == c.nbr)
                    begin
                        if (tbl_cost[i] != cur_inf)
                            r.changed = 1'b1;
                        tbl_cost[i] = cur_inf;
                    end
            end
            CMD_READ:
            begin
                if (c.idx >= tbl_count)
                    r.status = STS_RANGE;
                else
                begin
                    r.dest = tbl_dest[c.idx];
                    r.hop  = tbl_hop[c.idx];
                    r.cost = tbl_cost[c.idx];
                    r.plen = tbl_len[c.idx];
                    r.path = tbl_path[c.idx];
                end
            end
            default: ;
        endcase
        r.entry_count = 5'(tbl_count);
        return r;
    endfunction

    task automatic send_route(route_cmd_t c);
        bit taken;
        in_valid       <= 1'b1;
        cmd            <= c.cmd;
        neighbor_id    <= c.nbr;
        link_cost      <= c.link;
        route_dest     <= c.rdest;
        route_cost     <= c.rcost;
        route_path_len <= c.rlen;
        route_path     <= c.rpath;
        entry_index    <= c.idx;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        pending_routes.push_back(predict_route(c));
        items_sent++;
        if (c.cmd == CMD_READ && c.idx < tbl_count)
            reads_ok++;
        if (!send_free && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MY_ID)
            cur_my_id = data[3:0];
        else
            cur_inf = data[15:0];
    endtask

    function automatic route_cmd_t mk(cmd_t op, logic [3:0] nbr, logic [15:0] link,
                                      logic [3:0] rdest, logic [15:0] rcost,
                                      logic [3:0] rlen, logic [31:0] rpath,
                                      logic [3:0] idx);
        route_cmd_t c;
        c.cmd = op; c.nbr = nbr; c.link = link; c.rdest = rdest;
        c.rcost = rcost; c.rlen = rlen; c.rpath = rpath; c.idx = idx;
        return c;
    endfunction

    function automatic logic [15:0] pick_cost();
        return ($urandom_range(99) < 70) ? 16'($urandom_range(0, 300)) : 16'($urandom());
    endfunction

    function automatic route_cmd_t random_route();
        int r;
        cmd_t op;
        r = $urandom_range(99);
        if (r < 3)       op = CMD_CLEAR;
        else if (r < 10) op = CMD_ADD_NBR;
        else if (r < 13) op = CMD_ADD_SELF;
        else if (r < 68) op = CMD_UPDATE;
        else if (r < 78) op = CMD_DEAD;
        else if (r < 96) op = CMD_READ;
        else             op = ($urandom_range(1) != 0) ? CMD_RSVD6 : CMD_RSVD7;
        return mk(op, 4'($urandom()), pick_cost(), 4'($urandom()), pick_cost(),
                  ($urandom_range(99) < 80) ? 4'($urandom_range(0, 7))
                                             : 4'($urandom_range(8, 15)),
                  $urandom(), 4'($urandom()));
    endfunction

    // receiver side
    bit      out_fire;
    result_t got;

    always @(negedge clk)
    begin
        out_fire = out_valid && !out_stall && rst_n;
        got.status      = status_t'(status);
        got.changed     = changed;
        got.entry_count = entry_count;
        got.dest        = out_dest;
        got.hop         = out_next_hop;
        got.cost        = out_cost;
        got.plen        = out_path_len;
        got.path        = out_path;
    end

    always @(posedge clk)
    begin
        if (out_fire)
        begin
            result_t want;
            out_fire = 0;
            results_seen++;
            if (pending_routes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", got);
            end
            else
            begin
                want = pending_routes.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
                out_stall <= !recv_free && ($urandom_range(99) < 35);
        end
    end

    task automatic test_directed;
        apb_write(ADDR_MY_ID, 32'd3);
        apb_write(ADDR_INF, 32'd999);
        send_route(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        send_route(mk(CMD_ADD_SELF, 0, 0, 0, 0, 0, 0, 0));
        send_route(mk(CMD_ADD_NBR, 4'd1, 16'd0, 0, 0, 0, 0, 0));
        send_route(mk(CMD_ADD_NBR, 4'd15, 16'hFFFF, 0, 0, 0, 0, 0));
        send_route(mk(CMD_UPDATE, 4'd1, 16'd5, 4'd9, 16'd10, 4'd2, 32'h0000_0091, 0));
        send_route(mk(CMD_UPDATE, 4'd1, 16'd5, 4'd9, 16'd10, 4'd2, 32'h0000_0091, 0));
        send_route(mk(CMD_UPDATE, 4'd1, 16'd5, 4'd9, 16'd20, 4'd2, 32'h0000_0091, 0));
        send_route(mk(CMD_UPDATE, 4'd2, 16'd1, 4'd9, 16'd1, 4'd2, 32'h0000_0032, 0));
        send_route(mk(CMD_UPDATE, 4'd2, 16'd1, 4'd9, 16'd1, 4'd2, 32'h0000_0092, 0));
        send_route(mk(CMD_UPDATE, 4'd4, 16'hFFFF, 4'd10, 16'hFFFF, 4'd1, 32'h4, 0));
        send_route(mk(CMD_UPDATE, 4'd4, 16'd1, 4'd11, 16'd1, 4'd8, 32'hFFFF_FFFF, 0));
        send_route(mk(CMD_UPDATE, 4'd2, 16'd1, 4'd9, 16'd0, 4'd15, 32'h8765_4321, 0));
        send_route(mk(CMD_UPDATE, 4'd5, 16'd0, 4'd12, 16'd0, 4'd0, 32'h0, 0));
        send_route(mk(CMD_DEAD, 4'd2, 0, 0, 0, 0, 0, 0));
        send_route(mk(CMD_DEAD, 4'd2, 0, 0, 0, 0, 0, 0));
        send_route(mk(CMD_RSVD6, 0, 0, 0, 0, 0, 0, 0));
        send_route(mk(CMD_RSVD7, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            send_route(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 4'(i)));
        send_route(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 4'd15));
        drain();
    endtask

    task automatic test_table_full;
        while (tbl_count < 16)
            send_route(mk(CMD_ADD_NBR, 4'($urandom()), pick_cost(), 0, 0, 0, 0, 0));
        send_route(mk(CMD_ADD_SELF, 0, 0, 0, 0, 0, 0, 0));
        send_route(mk(CMD_UPDATE, 4'd1, 16'd1, 4'(cur_my_id + 1), 16'd1, 4'd1, 0, 0));
        send_route(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 4'd15));
        full_drops += 2;
        send_route(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_random_phase(logic [3:0] id, logic [15:0] inf, int n);
        apb_write(ADDR_MY_ID, {28'd0, id});
        apb_write(ADDR_INF, {16'd0, inf});
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
            begin
                send_free = 1;
                recv_free = 1;
            end
            if (i == n / 2 + 40)
            begin
                send_free = 0;
                recv_free = 0;
            end
            send_route(random_route());
        end
        drain();
    endtask

    task automatic test_backpressure;
        hold_left = 300;
        send_free = 1;
        for (int i = 0; i < 40; i++)
            send_route(random_route());
        send_free = 0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; cmd = '0; neighbor_id = '0; link_cost = '0; route_dest = '0;
        route_cost = '0; route_path_len = '0; route_path = '0; entry_index = '0;
        out_stall = 0;
        tbl_count = 0; cur_my_id = '0; cur_inf = 16'd999;
        mismatches = 0; items_sent = 0; results_seen = 0; reads_ok = 0; full_drops = 0;
        send_free = 0; recv_free = 0; hold_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random_phase(4'd0, 16'd999, 200);
        test_backpressure();
        test_random_phase(4'd15, 16'd1, 180);
        test_random_phase(4'($urandom()), 16'hFFFF, 200);
        test_table_full();
        test_random_phase(4'($urandom()), 16'd200, 200);
        $display("covered %0d transactions (%0d in-range reads), all commands, full table",
                 items_sent, reads_ok);
        $display("with %0d drop attempts, several infinity costs, long output hold-off; %0d results",
                 full_drops, results_seen);
        if (mismatches == 0 && pending_routes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
